// ===== hw/rtl/rsnwpa_pkg.sv =====
// ============================================================================
// RSN/WPA element parser package
// Parse phases, field codes and the suite decoding tables shared by the
// parser core.
// ============================================================================
package rsnwpa_pkg;

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_LEN   = 4'd1,
        PH_OUI   = 4'd2,
        PH_VER   = 4'd3,
        PH_GRP   = 4'd4,
        PH_PCNT  = 4'd5,
        PH_PLIST = 4'd6,
        PH_ACNT  = 4'd7,
        PH_ALIST = 4'd8,
        PH_CAPS  = 4'd9,
        PH_DONE  = 4'd10,
        PH_ERR   = 4'd11
    } phase_t;

    localparam logic [7:0] TAG_RSN    = 8'd48;
    localparam logic [7:0] TAG_VENDOR = 8'd221;

    localparam logic [1:0] PROTO_NONE = 2'd0;
    localparam logic [1:0] PROTO_RSN  = 2'd1;
    localparam logic [1:0] PROTO_WPA  = 2'd2;

    localparam logic [2:0] CIPHER_NONE    = 3'd0;
    localparam logic [2:0] CIPHER_WEP40   = 3'd1;
    localparam logic [2:0] CIPHER_TKIP    = 3'd2;
    localparam logic [2:0] CIPHER_CCMP    = 3'd3;
    localparam logic [2:0] CIPHER_WEP104  = 3'd4;
    localparam logic [2:0] CIPHER_CMAC128 = 3'd5;
    localparam logic [2:0] CIPHER_UNKNOWN = 3'd6;

    localparam logic [2:0] KM_NONE       = 3'd0;
    localparam logic [2:0] KM_IEEE8021X  = 3'd1;
    localparam logic [2:0] KM_PSK        = 3'd2;
    localparam logic [2:0] KM_PSK_SHA256 = 3'd3;
    localparam logic [2:0] KM_SAE        = 3'd4;

    // Vendor OUI 00:50:f2 followed by the WPA element type.
    function automatic logic [7:0] oui_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h00;
            2'd1:    r = 8'h50;
            2'd2:    r = 8'hf2;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] cipher_code(input logic [7:0] t);
        logic [2:0] r;
        case (t)
            8'd1:    r = CIPHER_WEP40;
            8'd2:    r = CIPHER_TKIP;
            8'd4:    r = CIPHER_CCMP;
            8'd5:    r = CIPHER_WEP104;
            8'd6:    r = CIPHER_CMAC128;
            default: r = CIPHER_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] akm_code(input logic [7:0] t, input logic rsn);
        logic [2:0] r;
        case (t)
            8'd1:    r = KM_IEEE8021X;
            8'd2:    r = KM_PSK;
            8'd6:    r = rsn ? KM_PSK_SHA256 : KM_PSK;
            8'd8:    r = KM_SAE;
            default: r = KM_PSK;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/rsn_wpa_ie_parser_core.sv =====
// ============================================================================
// RSN/WPA element parser core
// Parses an RSN or WPA security element one byte per transfer and gives one
// decoded result transfer on the byte marked last.
// ============================================================================
//
//  Channel  Dir  Signals                     Contents
//  s_*      in   tvalid tready tdata tlast   element byte, last-byte mark
//  m_*      out  tvalid tready tdata tuser   decoded fields, error flag
//
// One byte is taken per cycle while the input side does not stall. A byte
// passes an input register, the parse state is then updated from it, and a
// last byte loads the result register. Reset clears the parse state and the
// valid flags of both registers. The input side stalls only when a last byte
// waits while the result register is full and not taken.
module rsn_wpa_ie_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ie_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // protocol, grp_cipher, pair_cipher,
                                   // key_management, capabilities, zero pad
    output logic        m_tuser    // parse_error
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic        out_error_reg;
    logic [26:0] out_fields_reg;

    rsnwpa_pkg::phase_t phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  end_reg, end_next;
    logic        rsn_reg, rsn_next;
    logic [15:0] count_reg, count_next;
    logic [17:0] skip_reg, skip_next;
    logic [7:0]  hold_reg, hold_next;
    logic [1:0]  proto_reg, proto_next;
    logic [2:0]  grp_reg, grp_next;
    logic [2:0]  pair_reg, pair_next;
    logic [2:0]  key_reg, key_next;
    logic [15:0] caps_reg, caps_next;

    logic        advance;
    logic        emit;
    logic        ignore;
    logic [7:0]  b;
    logic [15:0] word;
    logic [17:0] skip_dec;
    logic        result_err;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign emit     = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;
    assign b        = in_byte_reg;
    assign word     = {b, hold_reg};
    assign skip_dec = (skip_reg != 18'd0) ? skip_reg - 18'd1 : skip_reg;
    assign ignore   = (phase_reg >= rsnwpa_pkg::PH_VER) && (pos_reg >= end_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = (pos_reg == 9'd511) ? pos_reg : pos_reg + 9'd1;
        end_next   = end_reg;
        rsn_next   = rsn_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        hold_next  = hold_reg;
        proto_next = proto_reg;
        grp_next   = grp_reg;
        pair_next  = pair_reg;
        key_next   = key_reg;
        caps_next  = caps_reg;

        if (!ignore)
        begin
            case (phase_reg)
                rsnwpa_pkg::PH_TAG:
                begin
                    skip_next = 18'd0;
                    if (b == rsnwpa_pkg::TAG_RSN)
                    begin
                        rsn_next   = 1'b1;
                        proto_next = rsnwpa_pkg::PROTO_RSN;
                        phase_next = rsnwpa_pkg::PH_LEN;
                    end
                    else if (b == rsnwpa_pkg::TAG_VENDOR)
                    begin
                        rsn_next   = 1'b0;
                        phase_next = rsnwpa_pkg::PH_LEN;
                    end
                    else
                    begin
                        phase_next = rsnwpa_pkg::PH_ERR;
                    end
                end
                rsnwpa_pkg::PH_LEN:
                begin
                    end_next   = {1'b0, b} + 9'd2;
                    skip_next  = 18'd0;
                    phase_next = rsn_reg ? rsnwpa_pkg::PH_VER : rsnwpa_pkg::PH_OUI;
                end
                rsnwpa_pkg::PH_OUI:
                begin
                    if (b != rsnwpa_pkg::oui_byte(skip_reg[1:0]))
                    begin
                        phase_next = rsnwpa_pkg::PH_ERR;
                        skip_next  = 18'd0;
                    end
                    else if (skip_reg[1:0] == 2'd3)
                    begin
                        proto_next = rsnwpa_pkg::PROTO_WPA;
                        phase_next = rsnwpa_pkg::PH_VER;
                        skip_next  = 18'd0;
                    end
                    else
                    begin
                        skip_next = {16'd0, skip_reg[1:0] + 2'd1};
                    end
                end
                rsnwpa_pkg::PH_VER:
                begin
                    if (skip_reg == 18'd1)
                    begin
                        phase_next = rsnwpa_pkg::PH_GRP;
                        skip_next  = 18'd0;
                    end
                    else
                    begin
                        skip_next = 18'd1;
                    end
                end
                rsnwpa_pkg::PH_GRP:
                begin
                    if (skip_reg >= 18'd3)
                    begin
                        grp_next   = rsnwpa_pkg::cipher_code(b);
                        phase_next = rsnwpa_pkg::PH_PCNT;
                        skip_next  = 18'd0;
                    end
                    else
                    begin
                        skip_next = skip_reg + 18'd1;
                    end
                end
                rsnwpa_pkg::PH_PCNT, rsnwpa_pkg::PH_ACNT:
                begin
                    if (skip_reg == 18'd0)
                    begin
                        hold_next = b;
                        skip_next = 18'd1;
                    end
                    else
                    begin
                        count_next = word;
                        if (word == 16'd0)
                        begin
                            skip_next  = 18'd0;
                            phase_next = (phase_reg == rsnwpa_pkg::PH_PCNT) ?
                                         rsnwpa_pkg::PH_ACNT : rsnwpa_pkg::PH_CAPS;
                        end
                        else
                        begin
                            skip_next  = {word, 2'b00};
                            phase_next = (phase_reg == rsnwpa_pkg::PH_PCNT) ?
                                         rsnwpa_pkg::PH_PLIST : rsnwpa_pkg::PH_ALIST;
                        end
                    end
                end
                rsnwpa_pkg::PH_PLIST, rsnwpa_pkg::PH_ALIST:
                begin
                    // The type byte of the first suite is its fourth byte.
                    if ({1'b0, skip_reg} + 19'd3 == {1'b0, count_reg, 2'b00})
                    begin
                        if (phase_reg == rsnwpa_pkg::PH_PLIST)
                            pair_next = rsnwpa_pkg::cipher_code(b);
                        else
                            key_next = rsnwpa_pkg::akm_code(b, rsn_reg);
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 18'd0)
                    begin
                        phase_next = (phase_reg == rsnwpa_pkg::PH_PLIST) ?
                                     rsnwpa_pkg::PH_ACNT : rsnwpa_pkg::PH_CAPS;
                    end
                end
                rsnwpa_pkg::PH_CAPS:
                begin
                    if (skip_reg == 18'd0)
                    begin
                        hold_next = b;
                        skip_next = 18'd1;
                    end
                    else
                    begin
                        caps_next  = word;
                        phase_next = rsnwpa_pkg::PH_DONE;
                        skip_next  = 18'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_err = (phase_next <= rsnwpa_pkg::PH_VER) ||
                        (phase_next >= rsnwpa_pkg::PH_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsnwpa_pkg::PH_TAG;
            pos_reg   <= 9'd0;
            end_reg   <= 9'd0;
            rsn_reg   <= 1'b0;
            count_reg <= 16'd0;
            skip_reg  <= 18'd0;
            hold_reg  <= 8'd0;
            proto_reg <= rsnwpa_pkg::PROTO_NONE;
            grp_reg   <= rsnwpa_pkg::CIPHER_NONE;
            pair_reg  <= rsnwpa_pkg::CIPHER_NONE;
            key_reg   <= rsnwpa_pkg::KM_NONE;
            caps_reg  <= 16'd0;
        end
        else if (emit)
        begin
            phase_reg <= rsnwpa_pkg::PH_TAG;
            pos_reg   <= 9'd0;
            end_reg   <= 9'd0;
            rsn_reg   <= 1'b0;
            count_reg <= 16'd0;
            skip_reg  <= 18'd0;
            hold_reg  <= 8'd0;
            proto_reg <= rsnwpa_pkg::PROTO_NONE;
            grp_reg   <= rsnwpa_pkg::CIPHER_NONE;
            pair_reg  <= rsnwpa_pkg::CIPHER_NONE;
            key_reg   <= rsnwpa_pkg::KM_NONE;
            caps_reg  <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            rsn_reg   <= rsn_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            hold_reg  <= hold_next;
            proto_reg <= proto_next;
            grp_reg   <= grp_next;
            pair_reg  <= pair_next;
            key_reg   <= key_next;
            caps_reg  <= caps_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_error_reg  <= result_err;
            out_fields_reg <= result_err ? 27'd0 :
                              {caps_next, key_next, pair_next, grp_next, proto_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_error_reg;
    assign m_tdata  = {5'd0, out_fields_reg};

endmodule
